### src/sfd_pkg.sv
// Shared types and constants for the SLIP frame decoder.
package sfd_pkg;

  localparam int MaxFrame   = 1024;
  localparam int CountWidth = $clog2(MaxFrame + 1);
  localparam int ByteWidth  = 8;
  localparam int IndexWidth = 10;
  localparam int LenWidth   = 11;
  localparam int CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_START_CODE       = 3'd0,
    CFG_END_CODE         = 3'd1,
    CFG_ESCAPE_CODE      = 3'd2,
    CFG_ESC_END_CODE     = 3'd3,
    CFG_ESC_ESCAPE_CODE  = 3'd4,
    CFG_ESC_START_CODE   = 3'd5
  } cfg_idx_t;

  localparam logic [ByteWidth-1:0] RstStartCode     = 8'd193;
  localparam logic [ByteWidth-1:0] RstEndCode       = 8'd192;
  localparam logic [ByteWidth-1:0] RstEscapeCode    = 8'd219;
  localparam logic [ByteWidth-1:0] RstEscEndCode    = 8'd220;
  localparam logic [ByteWidth-1:0] RstEscEscapeCode = 8'd221;
  localparam logic [ByteWidth-1:0] RstEscStartCode  = 8'd222;

  typedef struct packed {
    logic [ByteWidth-1:0] start_code;
    logic [ByteWidth-1:0] end_code;
    logic [ByteWidth-1:0] escape_code;
    logic [ByteWidth-1:0] escaped_end_code;
    logic [ByteWidth-1:0] escaped_escape_code;
    logic [ByteWidth-1:0] escaped_start_code;
  } codes_t;

  typedef struct packed {
    logic                  in_frame;
    logic                  escape_pending;
    logic [CountWidth-1:0] byte_count;
    logic                  overflowed;
  } state_t;

  typedef struct packed {
    logic                  frame_end;
    logic [ByteWidth-1:0]  data_byte;
    logic [IndexWidth-1:0] byte_index;
    logic [LenWidth-1:0]   frame_length;
    logic                  overflow;
  } result_t;

endpackage

### src/sfd_decode.sv
// Per-byte classification, next frame state and result for one received item.
module sfd_decode (
  input  logic [sfd_pkg::ByteWidth-1:0] rx_byte,
  input  sfd_pkg::codes_t               codes,
  input  sfd_pkg::state_t               state,
  output sfd_pkg::state_t               state_next,
  output logic                          emit,
  output sfd_pkg::result_t              result
);

  logic [sfd_pkg::ByteWidth-1:0] data;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    result     = '0;
    data       = rx_byte;
    if (rx_byte == codes.start_code) begin
      state_next.in_frame   = 1'b1;
      state_next.byte_count = '0;
      state_next.overflowed = 1'b0;
    end else if (rx_byte == codes.end_code) begin
      if (state.in_frame) begin
        emit                = 1'b1;
        result.frame_end    = 1'b1;
        result.frame_length = sfd_pkg::LenWidth'(state.byte_count);
        result.overflow     = state.overflowed;
      end
      state_next.in_frame = 1'b0;
    end else if (state.in_frame) begin
      if (rx_byte == codes.escape_code) begin
        state_next.escape_pending = 1'b1;
      end else begin
        if (state.escape_pending) begin
          if (rx_byte == codes.escaped_end_code) begin
            data = codes.end_code;
            state_next.escape_pending = 1'b0;
          end else if (rx_byte == codes.escaped_escape_code) begin
            data = codes.escape_code;
            state_next.escape_pending = 1'b0;
          end else if (rx_byte == codes.escaped_start_code) begin
            data = codes.start_code;
            state_next.escape_pending = 1'b0;
          end
        end
        if (state.byte_count >= sfd_pkg::CountWidth'(sfd_pkg::MaxFrame)) begin
          state_next.overflowed = 1'b1;
        end else begin
          emit                  = 1'b1;
          result.data_byte      = data;
          result.byte_index     = sfd_pkg::IndexWidth'(state.byte_count);
          result.overflow       = state.overflowed;
          state_next.byte_count = state.byte_count + 1'b1;
        end
      end
    end
  end

endmodule

### src/slip_frame_decoder_unit.sv
// Top level of the SLIP frame decoder: config registers, frame state and output skid.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte                | in
//  output  | out_valid, out_stall, frame_end, data_byte,| out
//          | byte_index, frame_length, overflow         |
//  config  | cfg_we, cfg_index, cfg_data                | in
//
// One item is accepted per cycle while in_stall is low; its result, if any, goes
// into the output register, or into the skid entry if the output register holds
// an item not taken. A two-entry output (register plus skid) keeps in_stall a
// registered signal: it rises only once both entries are full. Synchronous reset
// clears the frame state and both valid flags and reloads the default codes.
module slip_frame_decoder_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sfd_pkg::ByteWidth-1:0]    rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_end,
  output logic [sfd_pkg::ByteWidth-1:0]    data_byte,
  output logic [sfd_pkg::IndexWidth-1:0]   byte_index,
  output logic [sfd_pkg::LenWidth-1:0]     frame_length,
  output logic                             overflow,
  input  logic                             cfg_we,
  input  logic [sfd_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [sfd_pkg::ByteWidth-1:0]    cfg_data
);

  sfd_pkg::codes_t  codes;
  sfd_pkg::state_t  state;
  sfd_pkg::state_t  state_next;
  sfd_pkg::result_t result_next;
  sfd_pkg::result_t out_item;
  sfd_pkg::result_t skid_item;
  logic             emit;
  logic             skid_valid;
  logic             accept;
  logic             take;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take     = out_valid && !out_stall;

  sfd_decode u_decode (
    .rx_byte    (rx_byte),
    .codes      (codes),
    .state      (state),
    .state_next (state_next),
    .emit       (emit),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.start_code          <= sfd_pkg::RstStartCode;
      codes.end_code            <= sfd_pkg::RstEndCode;
      codes.escape_code         <= sfd_pkg::RstEscapeCode;
      codes.escaped_end_code    <= sfd_pkg::RstEscEndCode;
      codes.escaped_escape_code <= sfd_pkg::RstEscEscapeCode;
      codes.escaped_start_code  <= sfd_pkg::RstEscStartCode;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::CFG_START_CODE:      codes.start_code          <= cfg_data;
        sfd_pkg::CFG_END_CODE:        codes.end_code            <= cfg_data;
        sfd_pkg::CFG_ESCAPE_CODE:     codes.escape_code         <= cfg_data;
        sfd_pkg::CFG_ESC_END_CODE:    codes.escaped_end_code    <= cfg_data;
        sfd_pkg::CFG_ESC_ESCAPE_CODE: codes.escaped_escape_code <= cfg_data;
        sfd_pkg::CFG_ESC_START_CODE:  codes.escaped_start_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (take) begin
          out_item   <= skid_item;
          skid_valid <= 1'b0;
        end
      end else if (accept && emit) begin
        if (out_valid && !take) begin
          skid_item  <= result_next;
          skid_valid <= 1'b1;
        end else begin
          out_item  <= result_next;
          out_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign frame_end    = out_item.frame_end;
  assign data_byte    = out_item.data_byte;
  assign byte_index   = out_item.byte_index;
  assign frame_length = out_item.frame_length;
  assign overflow     = out_item.overflow;

endmodule
